// ===== rtl/irpfd_pkg.sv =====
// Types and constants shared by the infrared pulse frame decoder.
package irpfd_pkg;

   localparam int unsigned NUM_REGS   = 8;
   localparam int unsigned REG_W      = 8;
   localparam int unsigned REG_IDX_W  = 3;
   localparam int unsigned TICK_W     = 8;
   localparam int unsigned BIT_CNT_W  = 6;
   localparam int unsigned NUM_BYTES  = 4;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 40;

   localparam logic [BIT_CNT_W-1:0] FRAME_BITS = 6'd32;
   localparam logic [7:0]           MSB_SET    = 8'h80;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_LEADER_LOW_MIN       = 3'd0,
      REG_LEADER_LOW_EXTRA_MAX = 3'd1,
      REG_LEADER_SPACE_MAX     = 3'd2,
      REG_LEADER_SPACE_MIN     = 3'd3,
      REG_BIT_MARK_MAX         = 3'd4,
      REG_PULSE_MIN            = 3'd5,
      REG_BIT_SPACE_MAX        = 3'd6,
      REG_ONE_THRESHOLD        = 3'd7
   } reg_idx_type;

   localparam logic [REG_W-1:0] RST_LEADER_LOW_MIN       = 8'd85;
   localparam logic [REG_W-1:0] RST_LEADER_LOW_EXTRA_MAX = 8'd60;
   localparam logic [REG_W-1:0] RST_LEADER_SPACE_MAX     = 8'd60;
   localparam logic [REG_W-1:0] RST_LEADER_SPACE_MIN     = 8'd40;
   localparam logic [REG_W-1:0] RST_BIT_MARK_MAX         = 8'd8;
   localparam logic [REG_W-1:0] RST_PULSE_MIN            = 8'd4;
   localparam logic [REG_W-1:0] RST_BIT_SPACE_MAX        = 8'd20;
   localparam logic [REG_W-1:0] RST_ONE_THRESHOLD        = 8'd10;

   typedef enum logic [4:0] {
      PH_LEAD_LOW  = 5'b00001,
      PH_LEAD_REST = 5'b00010,
      PH_LEAD_SPC  = 5'b00100,
      PH_BIT_MARK  = 5'b01000,
      PH_BIT_SPC   = 5'b10000
   } phase_type;

endpackage

// ===== rtl/ir_pulse_frame_decoder_core.sv =====
// Top level of the infrared pulse frame decoder: phase machine, counters and result register.
// Each accepted request word is one line sample tick and yields exactly one response word.
// The decoder state and the response register are updated at the edge that accepts the
// sample, so the response appears in the cycle after it. A word can be accepted every cycle
// while the response register, the only buffer, is empty or being drained in the same cycle.
// Configuration writes take effect on the next edge.
module ir_pulse_frame_decoder_core
   import irpfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // Fields from bit 0: line_level, release_req, zero fill.
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // Fields from bit 0: frame_ready, timing_error, first_byte, second_byte,
   // third_byte, fourth_byte, zero fill.
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [REG_IDX_W-1:0]  csr_addr,
   input  logic [REG_W-1:0]      csr_wdata
);

   logic [REG_W-1:0] regs_ff [NUM_REGS];

   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BIT_CNT_W-1:0]   bitc_ff, bitc_in;
   logic [7:0]             shift_ff, shift_in;
   logic [7:0]             fbytes_ff [NUM_BYTES];
   logic [7:0]             fbytes_in [NUM_BYTES];
   logic                   ready_ff, ready_in;
   logic                   err;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   high;
   logic                   ready_eff;
   logic [TICK_W-1:0]      tick_inc;
   logic [7:0]             shift_bit;
   logic [BIT_CNT_W-1:0]   bitc_inc;
   logic [1:0]             byte_idx;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign high      = req_tdata[0];
   assign ready_eff = ready_ff && !req_tdata[1];
   assign tick_inc  = tick_ff + 1'b1;
   assign bitc_inc  = bitc_ff + 1'b1;
   assign byte_idx  = bitc_inc[4:3] - 2'd1;
   assign shift_bit = (tick_ff > regs_ff[REG_ONE_THRESHOLD]) ? (shift_ff | MSB_SET) : shift_ff;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      bitc_in   = bitc_ff;
      shift_in  = shift_ff;
      fbytes_in = fbytes_ff;
      ready_in  = ready_eff;
      err       = 1'b0;
      if (!ready_eff) begin
         unique case (phase_ff)
            PH_LEAD_LOW: begin
               if (!high) begin
                  if (tick_inc > regs_ff[REG_LEADER_LOW_MIN]) begin
                     phase_in = PH_LEAD_REST;
                     tick_in  = '0;
                  end else begin
                     tick_in = tick_inc;
                  end
               end else begin
                  tick_in = '0;
               end
            end
            PH_LEAD_REST: begin
               if (!high) begin
                  if (tick_inc > regs_ff[REG_LEADER_LOW_EXTRA_MAX]) begin
                     err = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end else begin
                  phase_in = PH_LEAD_SPC;
                  tick_in  = '0;
                  shift_in = '0;
                  bitc_in  = '0;
               end
            end
            PH_LEAD_SPC: begin
               if (high) begin
                  if (tick_inc > regs_ff[REG_LEADER_SPACE_MAX]) begin
                     err = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end else if (tick_inc < regs_ff[REG_LEADER_SPACE_MIN]) begin
                  err = 1'b1;
               end else begin
                  phase_in = PH_BIT_MARK;
                  tick_in  = '0;
                  shift_in = '0;
                  bitc_in  = '0;
               end
            end
            PH_BIT_MARK: begin
               if (!high) begin
                  if (tick_inc > regs_ff[REG_BIT_MARK_MAX]) begin
                     err = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end else if (tick_ff < regs_ff[REG_PULSE_MIN]) begin
                  err = 1'b1;
               end else begin
                  phase_in = PH_BIT_SPC;
                  tick_in  = '0;
               end
            end
            PH_BIT_SPC: begin
               if (high) begin
                  if (tick_inc > regs_ff[REG_BIT_SPACE_MAX]) begin
                     err = 1'b1;
                  end else begin
                     tick_in = tick_inc;
                  end
               end else if (tick_ff < regs_ff[REG_PULSE_MIN]) begin
                  err = 1'b1;
               end else begin
                  phase_in = PH_BIT_MARK;
                  tick_in  = '0;
                  bitc_in  = bitc_inc;
                  if (bitc_inc == FRAME_BITS) begin
                     fbytes_in[NUM_BYTES-1] = shift_bit;
                     ready_in = 1'b1;
                     phase_in = PH_LEAD_LOW;
                     bitc_in  = '0;
                     shift_in = '0;
                  end else if (bitc_inc[2:0] == 3'd0) begin
                     fbytes_in[byte_idx] = shift_bit;
                     shift_in = '0;
                  end else begin
                     shift_in = shift_bit >> 1;
                  end
               end
            end
            default: begin
               phase_in = PH_LEAD_LOW;
               tick_in  = '0;
               bitc_in  = '0;
               shift_in = '0;
            end
         endcase
         if (err) begin
            phase_in = PH_LEAD_LOW;
            tick_in  = '0;
            bitc_in  = '0;
            shift_in = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'd0, fbytes_in[3], fbytes_in[2], fbytes_in[1], fbytes_in[0],
                         err, ready_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff[REG_LEADER_LOW_MIN]       <= RST_LEADER_LOW_MIN;
         regs_ff[REG_LEADER_LOW_EXTRA_MAX] <= RST_LEADER_LOW_EXTRA_MAX;
         regs_ff[REG_LEADER_SPACE_MAX]     <= RST_LEADER_SPACE_MAX;
         regs_ff[REG_LEADER_SPACE_MIN]     <= RST_LEADER_SPACE_MIN;
         regs_ff[REG_BIT_MARK_MAX]         <= RST_BIT_MARK_MAX;
         regs_ff[REG_PULSE_MIN]            <= RST_PULSE_MIN;
         regs_ff[REG_BIT_SPACE_MAX]        <= RST_BIT_SPACE_MAX;
         regs_ff[REG_ONE_THRESHOLD]        <= RST_ONE_THRESHOLD;
      end else if (csr_we) begin
         regs_ff[csr_addr] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD_LOW;
         tick_ff      <= '0;
         bitc_ff      <= '0;
         shift_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BYTES; i++) begin
            fbytes_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
            bitc_ff   <= bitc_in;
            shift_ff  <= shift_in;
            ready_ff  <= ready_in;
            fbytes_ff <= fbytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // An aborted frame never reports a held frame in the same word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[1] |-> !rsp_data_ff[0])
      else $error("timing error reported together with frame ready");

   // A held frame leaves the receiver waiting for a leader with cleared counters.
   assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (phase_ff == PH_LEAD_LOW) && (bitc_ff == '0) && (tick_ff == '0))
      else $error("receiver not idle while a frame is held");

   // The frame flag is only set by the last bit space of a frame.
   assert property (@(posedge clock) disable iff (reset)
      $rose(ready_ff) |-> $past(phase_ff == PH_BIT_SPC) && $past(accept))
      else $error("frame ready set outside a bit space");

   // The bit counter never holds a full frame count.
   assert property (@(posedge clock) disable iff (reset)
      bitc_ff < FRAME_BITS)
      else $error("bit counter reached a full frame");

endmodule
